// ===== design/line_intersection_test_core_assert.svh =====
// assertion macros for the line intersection test core
`ifndef LINE_INTERSECTION_TEST_CORE_ASSERT_SVH
`define LINE_INTERSECTION_TEST_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while in reset
`define LIT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lit assertion failed");

// next-cycle implication, disabled while in reset
`define LIT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lit assertion failed");

`else

`define LIT_ASSERT_IMPL(label, ante, cons)
`define LIT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== design/lit_pkg.sv =====
// shared widths, codes and stage payload types for the line intersection test
`timescale 1ns / 1ps
`default_nettype none

package lit_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH + 2;
    localparam int NUM_WIDTH   = PROD_WIDTH + 1;
    localparam int TOL_WIDTH   = 34;
    localparam int CMP_WIDTH   = (NUM_WIDTH > TOL_WIDTH) ? NUM_WIDTH : TOL_WIDTH;

    // first line kinds
    localparam logic [1:0] LINE_SEGMENT = 2'd0;
    localparam logic [1:0] LINE_RAY     = 2'd1;
    localparam logic [1:0] LINE_FULL    = 2'd2;
    // undefined kind, never reports a hit
    localparam logic [1:0] LINE_UNDEF   = 2'd3;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] p_x;
        logic signed [COORD_WIDTH-1:0] p_y;
        logic signed [COORD_WIDTH-1:0] q_x;
        logic signed [COORD_WIDTH-1:0] q_y;
        logic signed [COORD_WIDTH-1:0] r_x;
        logic signed [COORD_WIDTH-1:0] r_y;
        logic signed [COORD_WIDTH-1:0] s_x;
        logic signed [COORD_WIDTH-1:0] s_y;
        logic [1:0]                    line_kind;
        logic                          exclude_ends;
    } t_item;

    typedef struct packed {
        logic intersects;
        logic parallel;
    } t_result;

    // per-item controls that ride along the pipe
    typedef struct packed {
        logic [1:0] line_kind;
        logic       strict;
    } t_ctrl;

    typedef struct packed {
        t_ctrl                        ctrl;
        logic signed [DIFF_WIDTH-1:0] m11;
        logic signed [DIFF_WIDTH-1:0] m12;
        logic signed [DIFF_WIDTH-1:0] m21;
        logic signed [DIFF_WIDTH-1:0] m22;
        logic signed [DIFF_WIDTH-1:0] v1;
        logic signed [DIFF_WIDTH-1:0] v2;
    } t_diff;

    typedef struct packed {
        t_ctrl                        ctrl;
        logic signed [PROD_WIDTH-1:0] det_a;
        logic signed [PROD_WIDTH-1:0] det_b;
        logic signed [PROD_WIDTH-1:0] na_a;
        logic signed [PROD_WIDTH-1:0] na_b;
        logic signed [PROD_WIDTH-1:0] nb_a;
        logic signed [PROD_WIDTH-1:0] nb_b;
    } t_prod;

    typedef struct packed {
        t_ctrl                       ctrl;
        logic signed [NUM_WIDTH-1:0] det;
        logic signed [NUM_WIDTH-1:0] na;
        logic signed [NUM_WIDTH-1:0] nb;
    } t_num;

endpackage

`default_nettype wire

// ===== design/lit_diff_stage.sv =====
// stage one: coordinate differences for the determinant and numerators
`timescale 1ns / 1ps
`default_nettype none

module lit_diff_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  lit_pkg::t_item i_item,
    output logic           o_valid,
    output lit_pkg::t_diff o_diff
);

    localparam int DW = lit_pkg::DIFF_WIDTH;

    logic           r_valid;
    lit_pkg::t_diff r_diff;
    lit_pkg::t_diff n_diff;

    always_comb begin
        n_diff.ctrl.line_kind = i_item.line_kind;
        n_diff.ctrl.strict    = i_item.exclude_ends;
        n_diff.m11 = DW'(i_item.q_x) - DW'(i_item.p_x);
        n_diff.m12 = DW'(i_item.r_x) - DW'(i_item.s_x);
        n_diff.m21 = DW'(i_item.q_y) - DW'(i_item.p_y);
        n_diff.m22 = DW'(i_item.r_y) - DW'(i_item.s_y);
        n_diff.v1  = DW'(i_item.r_x) - DW'(i_item.p_x);
        n_diff.v2  = DW'(i_item.r_y) - DW'(i_item.p_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff <= n_diff;
    end

    assign o_valid = r_valid;
    assign o_diff  = r_diff;

endmodule

`default_nettype wire

// ===== design/lit_mul_stage.sv =====
// stage two: the six cross products
`timescale 1ns / 1ps
`default_nettype none

module lit_mul_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  lit_pkg::t_diff i_diff,
    output logic           o_valid,
    output lit_pkg::t_prod o_prod
);

    localparam int PW = lit_pkg::PROD_WIDTH;

    logic           r_valid;
    lit_pkg::t_prod r_prod;
    lit_pkg::t_prod n_prod;

    always_comb begin
        n_prod.ctrl  = i_diff.ctrl;
        n_prod.det_a = PW'(i_diff.m11) * PW'(i_diff.m22);
        n_prod.det_b = PW'(i_diff.m12) * PW'(i_diff.m21);
        n_prod.na_a  = PW'(i_diff.m22) * PW'(i_diff.v1);
        n_prod.na_b  = PW'(i_diff.m12) * PW'(i_diff.v2);
        n_prod.nb_a  = PW'(i_diff.m11) * PW'(i_diff.v2);
        n_prod.nb_b  = PW'(i_diff.m21) * PW'(i_diff.v1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

`default_nettype wire

// ===== design/lit_sum_stage.sv =====
// stages three and four: product differences, then sign fold of the determinant
`timescale 1ns / 1ps
`default_nettype none

module lit_sum_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  lit_pkg::t_prod i_prod,
    output logic           o_valid,
    output lit_pkg::t_num  o_num
);

    localparam int NW = lit_pkg::NUM_WIDTH;

    logic          r_sum_valid;
    logic          r_fold_valid;
    lit_pkg::t_num r_sum;
    lit_pkg::t_num n_sum;
    lit_pkg::t_num r_fold;
    lit_pkg::t_num n_fold;
    logic          det_neg;

    always_comb begin
        n_sum.ctrl = i_prod.ctrl;
        n_sum.det  = NW'(i_prod.det_a) - NW'(i_prod.det_b);
        n_sum.na   = NW'(i_prod.na_a) - NW'(i_prod.na_b);
        n_sum.nb   = NW'(i_prod.nb_a) - NW'(i_prod.nb_b);
    end

    // make the determinant positive, numerators follow its sign
    assign det_neg = r_sum.det[NW-1];

    always_comb begin
        n_fold.ctrl = r_sum.ctrl;
        n_fold.det  = det_neg ? -r_sum.det : r_sum.det;
        n_fold.na   = det_neg ? -r_sum.na  : r_sum.na;
        n_fold.nb   = det_neg ? -r_sum.nb  : r_sum.nb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid  <= 1'b0;
            r_fold_valid <= 1'b0;
        end else begin
            r_sum_valid  <= i_valid;
            r_fold_valid <= r_sum_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_fold <= n_fold;
    end

    assign o_valid = r_fold_valid;
    assign o_num   = r_fold;

endmodule

`default_nettype wire

// ===== design/lit_test_stage.sv =====
// stage five: tolerance check and parameter bound tests
`timescale 1ns / 1ps
`default_nettype none

`include "line_intersection_test_core_assert.svh"

module lit_test_stage (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  lit_pkg::t_num                  i_num,
    input  logic [lit_pkg::TOL_WIDTH-1:0]  i_tol,
    output logic                           o_valid,
    output lit_pkg::t_result               o_result
);

    localparam int NW  = lit_pkg::NUM_WIDTH;
    localparam int CMW = lit_pkg::CMP_WIDTH;
    localparam logic signed [NW-1:0] NUM_ZERO = '0;

    logic             r_valid;
    lit_pkg::t_result r_result;
    lit_pkg::t_result n_result;
    logic [CMW-1:0]   det_ext;
    logic [CMW-1:0]   tol_ext;
    logic             par;
    logic             na_lo_ok;
    logic             na_hi_ok;
    logic             nb_ok;
    logic             kind_ok;

    // folded determinant is never negative
    assign det_ext = CMW'($unsigned(i_num.det));
    assign tol_ext = CMW'(i_tol);
    assign par     = (det_ext <= tol_ext);

    always_comb begin
        if (i_num.ctrl.strict) begin
            na_lo_ok = (i_num.na > NUM_ZERO);
            na_hi_ok = (i_num.na < i_num.det);
            nb_ok    = (i_num.nb > NUM_ZERO) && (i_num.nb < i_num.det);
        end else begin
            na_lo_ok = (i_num.na >= NUM_ZERO);
            na_hi_ok = (i_num.na <= i_num.det);
            nb_ok    = (i_num.nb >= NUM_ZERO) && (i_num.nb <= i_num.det);
        end
    end

    always_comb begin
        unique case (i_num.ctrl.line_kind)
            lit_pkg::LINE_SEGMENT: kind_ok = na_lo_ok && na_hi_ok;
            lit_pkg::LINE_RAY:     kind_ok = na_lo_ok;
            lit_pkg::LINE_FULL:    kind_ok = 1'b1;
            default:               kind_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_result.parallel   = par;
        n_result.intersects = !par && nb_ok && kind_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // undefined line kind never reports a hit
    `LIT_ASSERT_NEXT(a_undef_kind_no_hit,
        i_valid && (i_num.ctrl.line_kind == lit_pkg::LINE_UNDEF), !o_result.intersects)
    // a zero determinant is always parallel
    `LIT_ASSERT_NEXT(a_zero_det_parallel, i_valid && (i_num.det == NUM_ZERO), o_result.parallel)

endmodule

`default_nettype wire

// ===== design/line_intersection_test_core.sv =====
// top level of the line intersection test core
`timescale 1ns / 1ps
`default_nettype none

`include "line_intersection_test_core_assert.svh"

// line intersection test core
// - input channel: drive i_item and raise start; the item is taken at a rising
//   edge where start is high and busy is low. busy is always low, so one item
//   is taken every cycle in which start is high, with no gaps.
// - result channel: o_valid marks a one-cycle strobe with o_result; the result
//   of an item passes the difference, product, sum, fold and output registers
//   and comes out in the order items went in. the receiver has no way to
//   stall, and the pipe never needs it.
// - pipe: differences, six 17x17 products, product differences, sign fold of
//   the determinant, then tolerance and bound compares into the output register.
//   the product stage sets the clock; throughput is one item per cycle.
// - config: i_cfg_we writes i_cfg_wdata into the parallel tolerance at the edge;
//   write it only while no item is in flight.
// - reset (i_rst_n low, synchronous): clears all valid bits and sets the
//   tolerance to zero; items in flight are dropped.
module line_intersection_test_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  lit_pkg::t_item                i_item,
    input  logic                          i_cfg_we,
    input  logic [lit_pkg::TOL_WIDTH-1:0] i_cfg_wdata,
    output logic                          o_valid,
    output lit_pkg::t_result              o_result
);

    logic [lit_pkg::TOL_WIDTH-1:0] r_tol;
    logic [lit_pkg::TOL_WIDTH-1:0] n_tol;

    logic           accept;
    logic           diff_valid;
    lit_pkg::t_diff diff;
    logic           prod_valid;
    lit_pkg::t_prod prod;
    logic           num_valid;
    lit_pkg::t_num  num;

    // fully pipelined, always ready
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // parallel tolerance register
    assign n_tol = i_cfg_we ? i_cfg_wdata : r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else begin
            r_tol <= n_tol;
        end
    end

    // coordinate differences
    lit_diff_stage u_diff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_item  (i_item),
        .o_valid (diff_valid),
        .o_diff  (diff)
    );

    // cross products
    lit_mul_stage u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (diff_valid),
        .i_diff  (diff),
        .o_valid (prod_valid),
        .o_prod  (prod)
    );

    // determinant and numerators, sign folded
    lit_sum_stage u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod_valid),
        .i_prod  (prod),
        .o_valid (num_valid),
        .o_num   (num)
    );

    // tolerance and bound tests, output register
    lit_test_stage u_test (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (num_valid),
        .i_num    (num),
        .i_tol    (r_tol),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // every accepted item comes out as a result strobe
    `LIT_ASSERT_IMPL(a_latency, accept, ##5 o_valid)
    // no result strobe without a matching accepted item
    `LIT_ASSERT_IMPL(a_no_spurious, o_valid, $past(accept, 5))
    // parallel lines never report a crossing
    `LIT_ASSERT_IMPL(a_par_no_hit, o_valid && o_result.parallel, !o_result.intersects)

endmodule

`default_nettype wire

// ===== bench/tb_line_intersection_test_core.sv =====
// testbench for the line intersection test core: directed and random line pairs, scored
`timescale 1ns / 1ps

module tb_line_intersection_test_core;

    localparam int PIPE_LATENCY    = 5;      // edge that takes an item to its result strobe
    localparam int MAX_GAP         = 12;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 108;
    localparam int DRAIN_LIMIT     = 400;
    localparam int RUN_LIMIT_NS    = 2_000_000;

    localparam int COORD_WIDTH = lit_pkg::COORD_WIDTH;
    localparam int TOL_WIDTH   = lit_pkg::TOL_WIDTH;
    localparam logic [TOL_WIDTH-1:0] TOL_MAX = '1;

    // how random coordinates are drawn
    localparam int STYLE_FULL  = 0;
    localparam int STYLE_SMALL = 1;
    localparam int STYLE_EDGE  = 2;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    lit_pkg::t_item       i_item      = '0;
    logic                 i_cfg_we    = 1'b0;
    logic [TOL_WIDTH-1:0] i_cfg_wdata = '0;
    logic                 o_valid;
    lit_pkg::t_result     o_result;

    // tolerance the block holds, as seen from the bench
    logic [TOL_WIDTH-1:0] tolerance_setting = '0;
    // one expected verdict per accepted item, oldest first
    lit_pkg::t_result     expected_crossings[$];

    int mismatch_count   = 0;
    int items_sent       = 0;
    int results_checked  = 0;
    int crossings_seen   = 0;
    int parallels_seen   = 0;
    int tolerance_writes = 0;
    int zero_gap_run     = 0;

    line_intersection_test_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bound check of a numerator against the folded determinant
    function automatic logic within_unit(longint n, longint d, logic strict);
        if (strict) return (n > 0) && (n < d);
        return (n >= 0) && (n <= d);
    endfunction

    // exact integer verdict for one pair; 64-bit signed holds every product and sum
    function automatic lit_pkg::t_result predict_crossing(lit_pkg::t_item pair,
                                                          logic [TOL_WIDTH-1:0] tol);
        longint dx_pq, dy_pq, dx_sr, dy_sr, off_x, off_y;
        longint det, num_a, num_b;
        logic   b_ok;
        lit_pkg::t_result verdict;
        dx_pq = longint'($signed(pair.q_x)) - longint'($signed(pair.p_x));
        dy_pq = longint'($signed(pair.q_y)) - longint'($signed(pair.p_y));
        // second line enters as r - s, so the determinant needs no extra negation
        dx_sr = longint'($signed(pair.r_x)) - longint'($signed(pair.s_x));
        dy_sr = longint'($signed(pair.r_y)) - longint'($signed(pair.s_y));
        off_x = longint'($signed(pair.r_x)) - longint'($signed(pair.p_x));
        off_y = longint'($signed(pair.r_y)) - longint'($signed(pair.p_y));

        det   = dx_pq * dy_sr - dx_sr * dy_pq;
        num_a = dy_sr * off_x - dx_sr * off_y;
        num_b = dx_pq * off_y - dy_pq * off_x;
        // fold the sign so all bounds compare against a positive determinant
        if (det < 0) begin
            det   = -det;
            num_a = -num_a;
            num_b = -num_b;
        end

        verdict.parallel   = (det <= longint'({{(64-TOL_WIDTH){1'b0}}, tol}));
        verdict.intersects = 1'b0;
        if (!verdict.parallel) begin
            // the second line is always a segment
            b_ok = within_unit(num_b, det, pair.exclude_ends);
            case (pair.line_kind)
                lit_pkg::LINE_SEGMENT: begin
                    verdict.intersects = b_ok && within_unit(num_a, det, pair.exclude_ends);
                end
                lit_pkg::LINE_RAY: begin
                    verdict.intersects = b_ok && (pair.exclude_ends ? num_a > 0 : num_a >= 0);
                end
                lit_pkg::LINE_FULL: begin
                    verdict.intersects = b_ok;
                end
                default: begin
                    verdict.intersects = 1'b0;
                end
            endcase
        end
        return verdict;
    endfunction

    function automatic lit_pkg::t_item make_pair(input int px, py, qx, qy, rx, ry, sx, sy,
                                                 input logic [1:0] kind, input logic excl);
        lit_pkg::t_item pair;
        pair.p_x          = px[COORD_WIDTH-1:0];
        pair.p_y          = py[COORD_WIDTH-1:0];
        pair.q_x          = qx[COORD_WIDTH-1:0];
        pair.q_y          = qy[COORD_WIDTH-1:0];
        pair.r_x          = rx[COORD_WIDTH-1:0];
        pair.r_y          = ry[COORD_WIDTH-1:0];
        pair.s_x          = sx[COORD_WIDTH-1:0];
        pair.s_y          = sy[COORD_WIDTH-1:0];
        pair.line_kind    = kind;
        pair.exclude_ends = excl;
        return pair;
    endfunction

    function automatic int draw_coord(int style);
        case (style)
            STYLE_SMALL: return int'($urandom_range(0, 16)) - 8;
            STYLE_EDGE: begin
                case ($urandom_range(0, 5))
                    0: return -32768;
                    1: return -32767;
                    2: return -1;
                    3: return 0;
                    4: return 32766;
                    default: return 32767;
                endcase
            end
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // sends one item after a random gap, with occasional back-to-back bursts;
    // called right after a rising edge, returns at the edge that took the item
    task automatic send_item(input lit_pkg::t_item pair);
        int gap;
        if (zero_gap_run > 0) begin
            zero_gap_run--;
            gap = 0;
        end else if ($urandom_range(0, 15) == 0) begin
            zero_gap_run = $urandom_range(8, 30);
            gap = 0;
        end else begin
            gap = $urandom_range(0, MAX_GAP);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= pair;
        do @(posedge i_clk); while (busy !== 1'b0);
        expected_crossings.push_back(predict_crossing(pair, tolerance_setting));
        items_sent++;
    endtask

    // stop sending and let every outstanding item come out
    task automatic settle_pipe();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (expected_crossings.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [TOL_WIDTH-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we          <= 1'b0;
        tolerance_setting  = value;
        tolerance_writes++;
    endtask

    // plain crossing with strict and inclusive bounds, then every line kind
    task automatic test_line_kinds();
        send_item(make_pair(-10, 0, 10, 0, 0, -10, 0, 10, lit_pkg::LINE_SEGMENT, 1'b0));
        send_item(make_pair(-10, 0, 10, 0, 0, -10, 0, 10, lit_pkg::LINE_SEGMENT, 1'b1));
        // first line stops short of the second: only ray and full line reach it
        send_item(make_pair(-10, 0, -5, 0, 0, -10, 0, 10, lit_pkg::LINE_SEGMENT, 1'b0));
        send_item(make_pair(-10, 0, -5, 0, 0, -10, 0, 10, lit_pkg::LINE_RAY, 1'b0));
        send_item(make_pair(-10, 0, -5, 0, 0, -10, 0, 10, lit_pkg::LINE_FULL, 1'b1));
        // undefined kind never reports a crossing
        send_item(make_pair(-10, 0, -5, 0, 0, -10, 0, 10, lit_pkg::LINE_UNDEF, 1'b0));
        // crossing lies behind the ray start
        send_item(make_pair(-5, 0, -10, 0, 0, -10, 0, 10, lit_pkg::LINE_RAY, 1'b0));
        send_item(make_pair(-5, 0, -10, 0, 0, -10, 0, 10, lit_pkg::LINE_FULL, 1'b0));
        // second segment misses even a full line
        send_item(make_pair(-10, 0, 10, 0, 0, 5, 0, 10, lit_pkg::LINE_FULL, 1'b0));
    endtask

    // touches at an endpoint count only with inclusive bounds
    task automatic test_endpoint_touches();
        send_item(make_pair(0, 0, 10, 0, 5, 0, 5, 10, lit_pkg::LINE_SEGMENT, 1'b0));
        send_item(make_pair(0, 0, 10, 0, 5, 0, 5, 10, lit_pkg::LINE_SEGMENT, 1'b1));
        send_item(make_pair(0, 0, 5, 0, 5, -5, 5, 5, lit_pkg::LINE_SEGMENT, 1'b0));
        send_item(make_pair(0, 0, 5, 0, 5, -5, 5, 5, lit_pkg::LINE_SEGMENT, 1'b1));
        send_item(make_pair(5, 0, 10, 0, 5, -5, 5, 5, lit_pkg::LINE_RAY, 1'b0));
        send_item(make_pair(5, 0, 10, 0, 5, -5, 5, 5, lit_pkg::LINE_RAY, 1'b1));
    endtask

    // coordinate extremes: widest determinant, degenerate pairs, an undefined kind
    task automatic test_field_extremes();
        send_item(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768,
                            lit_pkg::LINE_SEGMENT, 1'b0));
        send_item(make_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                            lit_pkg::LINE_SEGMENT, 1'b0));
        send_item(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                            lit_pkg::LINE_FULL, 1'b1));
        send_item(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767,
                            lit_pkg::LINE_UNDEF, 1'b1));
    endtask

    // parallel and collinear pairs, then a small crossing around the tolerance
    task automatic test_parallel_tolerance();
        send_item(make_pair(0, 0, 10, 0, 5, 0, 20, 0, lit_pkg::LINE_SEGMENT, 1'b0));
        send_item(make_pair(0, 0, 10, 0, 0, 1, 10, 1, lit_pkg::LINE_FULL, 1'b0));
        // determinant magnitude of this pair is 4
        send_item(make_pair(0, 0, 2, 0, 1, -1, 1, 1, lit_pkg::LINE_SEGMENT, 1'b0));
        settle_pipe();
        write_tolerance(34'd3);
        send_item(make_pair(0, 0, 2, 0, 1, -1, 1, 1, lit_pkg::LINE_SEGMENT, 1'b0));
        settle_pipe();
        write_tolerance(34'd4);
        send_item(make_pair(0, 0, 2, 0, 1, -1, 1, 1, lit_pkg::LINE_SEGMENT, 1'b0));
        settle_pipe();
        // full-scale tolerance swallows even the widest determinant
        write_tolerance(TOL_MAX);
        send_item(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768,
                            lit_pkg::LINE_SEGMENT, 1'b0));
    endtask

    // random pairs under a sweep of tolerances; 9 in 20 are built to land near or on
    // the first line, the rest are small-grid, full-range or extreme coordinates
    task automatic test_random_phases();
        logic [TOL_WIDTH-1:0] tol_choice [RANDOM_PHASES];
        lit_pkg::t_item pair;
        logic [1:0]     kind;
        int shape, style, kind_draw;
        int px, py, dx, dy, k, j, mid_x, mid_y, off_x, off_y;
        tol_choice[0] = '0;
        tol_choice[1] = 34'd2;
        tol_choice[2] = TOL_WIDTH'($urandom_range(0, 300));
        tol_choice[3] = TOL_WIDTH'($urandom_range(0, 1 << 26));
        tol_choice[4] = TOL_WIDTH'({$urandom, $urandom});
        tol_choice[5] = TOL_MAX;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle_pipe();
            write_tolerance(tol_choice[ph]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                kind_draw = $urandom_range(0, 9);
                if (kind_draw < 3)      kind = lit_pkg::LINE_SEGMENT;
                else if (kind_draw < 6) kind = lit_pkg::LINE_RAY;
                else if (kind_draw < 9) kind = lit_pkg::LINE_FULL;
                else                    kind = lit_pkg::LINE_UNDEF;
                shape = $urandom_range(0, 19);
                if (shape < 9) begin
                    // q = p + 4d; the crossing point sits at a = k/4 along the first line
                    px    = int'($urandom_range(0, 16000)) - 8000;
                    py    = int'($urandom_range(0, 16000)) - 8000;
                    dx    = int'($urandom_range(0, 4000)) - 2000;
                    dy    = int'($urandom_range(0, 4000)) - 2000;
                    k     = int'($urandom_range(0, 6)) - 1;
                    mid_x = px + k * dx;
                    mid_y = py + k * dy;
                    off_x = int'($urandom_range(0, 8000)) - 4000;
                    off_y = int'($urandom_range(0, 8000)) - 4000;
                    // second segment: degenerate, ending on the point, or centered on it
                    j     = $urandom_range(0, 2);
                    pair  = make_pair(px, py, px + 4 * dx, py + 4 * dy,
                                      mid_x + off_x, mid_y + off_y,
                                      mid_x - (j - 1) * off_x, mid_y - (j - 1) * off_y,
                                      kind, 1'($urandom_range(0, 1)));
                end else begin
                    if (shape < 13)      style = STYLE_SMALL;
                    else if (shape < 18) style = STYLE_FULL;
                    else                 style = STYLE_EDGE;
                    pair = make_pair(draw_coord(style), draw_coord(style),
                                     draw_coord(style), draw_coord(style),
                                     draw_coord(style), draw_coord(style),
                                     draw_coord(style), draw_coord(style),
                                     kind, 1'($urandom_range(0, 1)));
                end
                send_item(pair);
            end
        end
    endtask

    // every strobe is scored against the oldest expected verdict
    always @(posedge i_clk) begin : crossing_checker
        lit_pkg::t_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_crossings.size() == 0) begin
                $error("unexpected result: intersects %0b parallel %0b",
                       o_result.intersects, o_result.parallel);
                mismatch_count++;
            end else begin
                want = expected_crossings.pop_front();
                results_checked++;
                if (want.intersects) crossings_seen++;
                if (want.parallel) parallels_seen++;
                if (o_result.intersects !== want.intersects) begin
                    $error("intersects: expected %0b, got %0b",
                           want.intersects, o_result.intersects);
                    mismatch_count++;
                end
                if (o_result.parallel !== want.parallel) begin
                    $error("parallel: expected %0b, got %0b",
                           want.parallel, o_result.parallel);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // tolerance still at its reset value of zero here
        test_line_kinds();
        test_endpoint_touches();
        test_field_extremes();
        settle_pipe();
        test_parallel_tolerance();
        test_random_phases();

        settle_pipe();
        if (expected_crossings.size() != 0) begin
            $error("%0d expected results never arrived", expected_crossings.size());
            mismatch_count++;
        end
        $display("run covered %0d line pairs over %0d tolerance settings",
                 items_sent, tolerance_writes + 1);
        $display("%0d verdicts scored: %0d crossings, %0d parallel pairs",
                 results_checked, crossings_seen, parallels_seen);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
